// ===== hdl/bpq_pkg.sv =====
// Shared types and codes for the bounded priority queue.
// Used by bounded_priority_queue; no dependencies.
package bpq_pkg;

    localparam int OCC_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // One stored job record, 48 bits.
    typedef struct packed {
        logic [3:0]  priority_val;
        logic [15:0] sequence_number;
        logic [7:0]  source_number;
        logic [2:0]  run_time;
        logic [16:0] tag;
    } record_t;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  priority_req;
        logic [15:0] sequence_number;
        logic [7:0]  source_number;
        logic [2:0]  run_time;
        logic [16:0] tag;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [3:0]       out_priority;
        logic [15:0]      out_sequence_number;
        logic [7:0]       out_source_number;
        logic [2:0]       out_run_time;
        logic [16:0]      out_tag;
        logic [OCC_W-1:0] occupancy;
    } result_t;

endpackage

// ===== hdl/bpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/bounded_priority_queue.sv =====
// Bounded priority queue top level: sequencer around one record RAM.
// Depends on bpq_pkg and bpq_ram.
//
// A request is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high, and the receiver cannot stall it.
// Records sit in a RAM sorted by priority, lower numbers first, and equal
// priorities leave in arrival order. An insert walks from the tail toward the
// head, moving each larger record down one place until its slot is found. A
// remove reads the head and then moves the rest up one place. Refused requests
// and an insert into an empty queue finish straight from idle. The single RAM
// read port moves one entry per cycle, and busy holds off new requests while
// a walk is in progress.
module bounded_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bpq_pkg::cmd_t     cmd,
    output logic              done,
    output bpq_pkg::result_t  result
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int OccW = bpq_pkg::OCC_W;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_INS_SCAN  = 5'b00010,
        S_INS_PLACE = 5'b00100,
        S_REM_HEAD  = 5'b01000,
        S_REM_SHIFT = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      count_reg, count_next;
    bpq_pkg::record_t   rec_reg, rec_next;
    bpq_pkg::result_t   res_reg, res_next;
    logic               done_reg, done_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    bpq_pkg::record_t   ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [47:0]        ram_rdata;
    bpq_pkg::record_t   ram_rec;

    assign ram_rec = bpq_pkg::record_t'(ram_rdata);

    bpq_ram #(
        .WIDTH ($bits(bpq_pkg::record_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        rec_next   = rec_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = rec_reg;
        ram_raddr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    if (cmd.opcode == bpq_pkg::OP_INSERT)
                    begin
                        rec_next.priority_val    = cmd.priority_req;
                        rec_next.sequence_number = cmd.sequence_number;
                        rec_next.source_number   = cmd.source_number;
                        rec_next.run_time        = cmd.run_time;
                        rec_next.tag             = cmd.tag;
                        if ({1'b0, count_reg} >= (CW + 1)'(CAPACITY))
                        begin
                            res_next.status = bpq_pkg::STATUS_FULL;
                            done_next       = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            ram_wdata  = rec_next;
                            count_next = CW'(1);
                            res_next.status = bpq_pkg::STATUS_DONE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            idx_next   = AW'(count_reg);
                            ram_raddr  = AW'(count_reg - CW'(1));
                            state_next = S_INS_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = bpq_pkg::STATUS_EMPTY;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            ram_raddr  = '0;
                            state_next = S_REM_HEAD;
                        end
                    end
                end
            end

            // Read data holds the entry just above the write slot.
            S_INS_SCAN:
            begin
                ram_we = 1'b1;
                if (ram_rec.priority_val > rec_reg.priority_val)
                begin
                    ram_waddr = idx_reg;
                    ram_wdata = ram_rec;
                    idx_next  = idx_reg - AW'(1);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = S_INS_PLACE;
                    end
                    else
                    begin
                        ram_raddr = idx_reg - AW'(2);
                    end
                end
                else
                begin
                    ram_waddr  = idx_reg;
                    ram_wdata  = rec_reg;
                    count_next = count_reg + CW'(1);
                    res_next.status = bpq_pkg::STATUS_DONE;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_INS_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = rec_reg;
                count_next = count_reg + CW'(1);
                res_next.status = bpq_pkg::STATUS_DONE;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_REM_HEAD:
            begin
                rec_next = ram_rec;
                if (count_reg == CW'(1))
                begin
                    count_next = '0;
                    res_next.status              = bpq_pkg::STATUS_DONE;
                    res_next.out_priority        = ram_rec.priority_val;
                    res_next.out_sequence_number = ram_rec.sequence_number;
                    res_next.out_source_number   = ram_rec.source_number;
                    res_next.out_run_time        = ram_rec.run_time;
                    res_next.out_tag             = ram_rec.tag;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_raddr  = AW'(1);
                    idx_next   = '0;
                    state_next = S_REM_SHIFT;
                end
            end

            // Read data holds the entry one below the write slot.
            S_REM_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rec;
                if ((CW + 1)'(idx_reg) + (CW + 1)'(2) < (CW + 1)'(count_reg))
                begin
                    ram_raddr = idx_reg + AW'(2);
                    idx_next  = idx_reg + AW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    res_next.status              = bpq_pkg::STATUS_DONE;
                    res_next.out_priority        = rec_reg.priority_val;
                    res_next.out_sequence_number = rec_reg.sequence_number;
                    res_next.out_source_number   = rec_reg.source_number;
                    res_next.out_run_time        = rec_reg.run_time;
                    res_next.out_tag             = rec_reg.tag;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            res_next.occupancy = OccW'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        rec_reg <= rec_next;
        res_reg <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} <= (CW + 1)'(CAPACITY))
        else $error("queue count exceeds capacity");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) && !$past(busy)) || $past(busy))
        else $error("result strobe without a request in progress");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither finished nor in progress");

    a_occupancy_match: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.occupancy == OccW'(count_reg)))
        else $error("reported occupancy differs from stored count");

    a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_SCAN) |-> (idx_reg != '0))
        else $error("insert walk reached the head without placing");

endmodule
